// ===== rtl/morse_key_decoder_top_assert.svh =====
// Assertion macros for the Morse key decoder.
// Used by morse_key_decoder_top; no other dependencies.
`ifndef MORSE_KEY_DECODER_TOP_ASSERT_SVH
`define MORSE_KEY_DECODER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// property held at every edge out of reset
`define MKD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent implies consequent in the next cycle
`define MKD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MKD_ASSERT(lbl, clk, rst_n, prop, msg)
`define MKD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/mkd_pkg.sv =====
// Shared types, constants and the code table lookup for the Morse key decoder.
// No dependencies.
`default_nettype none

package mkd_pkg;

  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SYM_W      = 8;   // widest symbol buffer supported
  localparam int unsigned LEN_W      = 4;   // widest symbol count supported
  localparam int unsigned LETTERS    = 26;
  localparam int unsigned LETTER_W   = 5;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned OUT_BITS_W = 4;
  localparam int unsigned OUT_LEN_W  = 3;

  localparam logic [CFG_W-1:0] DOT_LIMIT_RST  = 16'd250;
  localparam logic [CFG_W-1:0] DASH_LIMIT_RST = 16'd700;
  localparam logic [CFG_W-1:0] GAP_LIMIT_RST  = 16'd400;

  typedef enum logic [KIND_W-1:0] {
    KIND_DOT     = 3'd0,
    KIND_DASH    = 3'd1,
    KIND_BAD     = 3'd2,
    KIND_LETTER  = 3'd3,
    KIND_INVALID = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOT_LIMIT  = 2'd0,
    REG_DASH_LIMIT = 2'd1,
    REG_GAP_LIMIT  = 2'd2
  } cfg_idx_e;

  // timing unit -> symbol buffer
  typedef struct packed {
    logic rel;       // release tick
    logic dot;
    logic dash;
    logic gap_over;  // idle spell has passed the gap limit
  } tm_evt_t;

  typedef struct packed {
    logic                  valid;
    kind_e                 kind;
    logic [LETTER_W-1:0]   letter;
    logic [OUT_BITS_W-1:0] bits;
    logic [OUT_LEN_W-1:0]  len;
  } res_t;

  typedef struct packed {
    logic [3:0] bits;
    logic [2:0] len;
  } code_entry_t;

  typedef struct packed {
    logic                hit;
    logic [LETTER_W-1:0] idx;
  } lookup_t;

  // A..Z, first symbol in bit 0, 1 = dash
  localparam code_entry_t CODE_ROM [LETTERS] = '{
    '{4'd2, 3'd2},  '{4'd1, 3'd4},  '{4'd5, 3'd4},  '{4'd1, 3'd3},
    '{4'd0, 3'd1},  '{4'd4, 3'd4},  '{4'd3, 3'd3},  '{4'd0, 3'd4},
    '{4'd0, 3'd2},  '{4'd14, 3'd4}, '{4'd5, 3'd3},  '{4'd2, 3'd4},
    '{4'd3, 3'd2},  '{4'd1, 3'd2},  '{4'd7, 3'd3},  '{4'd6, 3'd4},
    '{4'd11, 3'd4}, '{4'd2, 3'd3},  '{4'd0, 3'd3},  '{4'd1, 3'd1},
    '{4'd4, 3'd3},  '{4'd8, 3'd4},  '{4'd6, 3'd3},  '{4'd9, 3'd4},
    '{4'd13, 3'd4}, '{4'd3, 3'd4}
  };

  function automatic lookup_t code_lookup(input logic [SYM_W-1:0] bits,
                                          input logic [LEN_W-1:0] len);
    lookup_t r;
    r = '0;
    for (int i = 0; i < LETTERS; i++) begin
      if (!r.hit && LEN_W'(CODE_ROM[i].len) == len && SYM_W'(CODE_ROM[i].bits) == bits) begin
        r.hit = 1'b1;
        r.idx = LETTER_W'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/morse_key_decoder_top.sv =====
// Morse key decoder top level: one key sample per request, 0 or 1 result per sample.
// A result is in the output register in the cycle after its sample is taken.
// Throughput: one sample per cycle; input stalls only while the output register holds
// a result the sink has not taken.
// Reset (rst_ni, async, active low) clears timers, symbol buffer and output valid;
// limits return to 250 / 700 / 400. Depends on mkd_pkg, mkd_timing, mkd_symbuf.
`default_nettype none

`include "morse_key_decoder_top_assert.svh"

module morse_key_decoder_top
  import mkd_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS     = 4,
  parameter int unsigned TICK_COUNT_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // key sample stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [0] key_level, rest zero
  // event stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [15:0]               m_axis_tdata,   // [4:0] letter_index, [8:5] code_bits,
                                                    // [11:9] code_length, rest zero
  output logic [KIND_W-1:0]         m_axis_tuser,   // [2:0] event_kind
  // register writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  // ---- limit registers: always ready, unknown index dropped ----
  logic [CFG_W-1:0] dot_limit_q, dash_limit_q, gap_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_limit_q  <= DOT_LIMIT_RST;
      dash_limit_q <= DASH_LIMIT_RST;
      gap_limit_q  <= GAP_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_DOT_LIMIT:  dot_limit_q  <= cfg_data_i;
        REG_DASH_LIMIT: dash_limit_q <= cfg_data_i;
        REG_GAP_LIMIT:  gap_limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- request accept: the output register frees up if it is empty or drains now ----
  logic    step;
  tm_evt_t evt;
  res_t    res;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  mkd_timing #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_timing (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .key_i        (s_axis_tdata[0]),
    .dot_limit_i  (dot_limit_q),
    .dash_limit_i (dash_limit_q),
    .gap_limit_i  (gap_limit_q),
    .evt_o        (evt)
  );

  // evt is all zero unless a sample is taken, so the buffer only moves on step
  mkd_symbuf #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_symbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt),
    .res_o  (res)
  );

  // ---- output register ----
  logic        out_valid_q;
  logic [15:0] out_data_q;
  logic [KIND_W-1:0] out_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      out_data_q <= {4'd0, res.len, res.bits, res.letter};
      out_kind_q <= res.kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

  // ---- checks ----
  `MKD_ASSERT(a_no_accept_on_stall, clk_i, rst_ni,
    !(m_axis_tvalid && !m_axis_tready && s_axis_tready), "sample taken while output stalled")
  `MKD_ASSERT_NEXT(a_result_lands, clk_i, rst_ni, step && res.valid,
    m_axis_tvalid, "result lost on its way to the output register")
  `MKD_ASSERT(a_decode_clears, clk_i, rst_ni,
    !(m_axis_tvalid && (m_axis_tuser == KIND_LETTER || m_axis_tuser == KIND_INVALID)
      && m_axis_tdata[11:5] != 7'd0), "buffer not cleared on decode")

endmodule

`default_nettype wire

// ===== rtl/mkd_timing.sv =====
// Press and idle timers with press classification.
// Depends on mkd_pkg.
`default_nettype none

module mkd_timing
  import mkd_pkg::*;
#(
  parameter int unsigned TICK_COUNT_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic             key_i,
  input  wire logic [CFG_W-1:0] dot_limit_i,
  input  wire logic [CFG_W-1:0] dash_limit_i,
  input  wire logic [CFG_W-1:0] gap_limit_i,
  output tm_evt_t               evt_o
);

  localparam int unsigned CMP_W = (TICK_COUNT_BITS > CFG_W) ? TICK_COUNT_BITS : CFG_W;

  logic                       down_q, down_d;
  logic [TICK_COUNT_BITS-1:0] press_q, press_d;
  logic [TICK_COUNT_BITS-1:0] idle_q, idle_d;
  logic [TICK_COUNT_BITS-1:0] idle_inc, press_inc;

  assign press_inc = (&press_q) ? press_q : press_q + TICK_COUNT_BITS'(1);
  assign idle_inc  = (&idle_q)  ? idle_q  : idle_q  + TICK_COUNT_BITS'(1);

  always_comb begin
    down_d  = down_q;
    press_d = press_q;
    idle_d  = idle_q;
    evt_o   = '0;
    if (step_i) begin
      if (key_i) begin
        press_d = down_q ? press_inc : TICK_COUNT_BITS'(1);
        down_d  = 1'b1;
      end else if (down_q) begin
        down_d     = 1'b0;
        idle_d     = '0;
        evt_o.rel  = 1'b1;
        evt_o.dot  = CMP_W'(press_q) < CMP_W'(dot_limit_i);
        evt_o.dash = !evt_o.dot && (CMP_W'(press_q) < CMP_W'(dash_limit_i));
      end else begin
        idle_d         = idle_inc;
        evt_o.gap_over = CMP_W'(idle_inc) > CMP_W'(gap_limit_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q  <= 1'b0;
      press_q <= '0;
      idle_q  <= '0;
    end else begin
      down_q  <= down_d;
      press_q <= press_d;
      idle_q  <= idle_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mkd_symbuf.sv =====
// Symbol buffer, overflow flag and letter decode; builds the result.
// Depends on mkd_pkg.
`default_nettype none

module mkd_symbuf
  import mkd_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  tm_evt_t   evt_i,
  output res_t      res_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SYMBOLS + 1);

  logic [MAX_SYMBOLS-1:0] bits_q, bits_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  lookup_t                look;

  assign look = code_lookup(SYM_W'(bits_q), LEN_W'(cnt_q));

  always_comb begin
    bits_d = bits_q;
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    res_o  = '0;
    if (evt_i.rel) begin
      res_o.valid = 1'b1;
      res_o.kind  = evt_i.dot ? KIND_DOT : (evt_i.dash ? KIND_DASH : KIND_BAD);
      if (evt_i.dot || evt_i.dash) begin
        if (cnt_q < CNT_W'(MAX_SYMBOLS)) begin
          for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (evt_i.dash && cnt_q == CNT_W'(i)) bits_d[i] = 1'b1;
          end
          cnt_d = cnt_q + CNT_W'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
      res_o.bits = bits_d[OUT_BITS_W-1:0];
      res_o.len  = cnt_d[OUT_LEN_W-1:0];
    end else if (evt_i.gap_over && cnt_q != '0) begin
      res_o.valid = 1'b1;
      if (!ovf_q && look.hit) begin
        res_o.kind   = KIND_LETTER;
        res_o.letter = look.idx;
      end else begin
        res_o.kind = KIND_INVALID;
      end
      bits_d = '0;
      cnt_d  = '0;
      ovf_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      bits_q <= bits_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

`default_nettype wire
